FILE: src/bba_pkg.sv
// shared codes, widths and types for the buddy allocator
package bba_pkg;

  localparam int PoolOrderDef = 10;
  localparam int OrdW         = 4;
  localparam int OpW          = 2;
  localparam int StW          = 3;

  localparam logic [OpW-1:0] OpAlloc  = 2'd0;
  localparam logic [OpW-1:0] OpFree   = 2'd1;
  localparam logic [OpW-1:0] OpResize = 2'd2;

  localparam logic [StW-1:0] StOk       = 3'd0;
  localparam logic [StW-1:0] StNoMem    = 3'd1;
  localparam logic [StW-1:0] StBadOrder = 3'd2;
  localparam logic [StW-1:0] StBadAddr  = 3'd3;
  localparam logic [StW-1:0] StIsFree   = 3'd4;

  typedef struct packed {
    logic mark;
    logic nxt;
    logic prv;
  } mem_we_t;

endpackage

FILE: src/bba_mem.sv
// per-unit memories: free mark with head order, next link, prev link
module bba_mem import bba_pkg::*; #(
  parameter int POOL_ORDER = PoolOrderDef
) (
  input  logic                            clk_i,
  input  logic [POOL_ORDER-1:0]           rd_addr_i,
  input  mem_we_t                         we_i,
  input  logic [POOL_ORDER-1:0]           mark_waddr_i,
  input  logic [$clog2(POOL_ORDER+1):0]   mark_wdata_i,
  input  logic [POOL_ORDER-1:0]           next_waddr_i,
  input  logic [POOL_ORDER:0]             next_wdata_i,
  input  logic [POOL_ORDER-1:0]           prev_waddr_i,
  input  logic [POOL_ORDER:0]             prev_wdata_i,
  output logic [$clog2(POOL_ORDER+1):0]   mark_rdata_o,
  output logic [POOL_ORDER:0]             next_rdata_o,
  output logic [POOL_ORDER:0]             prev_rdata_o
);

  localparam int AW    = POOL_ORDER;
  localparam int OW    = $clog2(POOL_ORDER + 1);
  localparam int Depth = 1 << POOL_ORDER;

  logic [OW:0] mark_mem [Depth];
  logic [AW:0] next_mem [Depth];
  logic [AW:0] prev_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i.mark) begin
      mark_mem[mark_waddr_i] <= mark_wdata_i;
    end
    mark_rdata_o <= mark_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.nxt) begin
      next_mem[next_waddr_i] <= next_wdata_i;
    end
    next_rdata_o <= next_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.prv) begin
      prev_mem[prev_waddr_i] <= prev_wdata_i;
    end
    prev_rdata_o <= prev_mem[rd_addr_i];
  end

endmodule

FILE: src/bba_ctrl.sv
// request sequencer with free list heads and tails
module bba_ctrl import bba_pkg::*; #(
  parameter int POOL_ORDER = PoolOrderDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [OpW-1:0]                  opcode_i,
  input  logic [POOL_ORDER-1:0]           block_address_i,
  input  logic [OrdW-1:0]                 order_i,
  input  logic [OrdW-1:0]                 new_order_i,
  output logic                            done_o,
  output logic [POOL_ORDER-1:0]           result_address_o,
  output logic [StW-1:0]                  status_o,
  output logic                            moved_o,
  output logic [POOL_ORDER-1:0]           rd_addr_o,
  output mem_we_t                         we_o,
  output logic [POOL_ORDER-1:0]           mark_waddr_o,
  output logic [$clog2(POOL_ORDER+1):0]   mark_wdata_o,
  output logic [POOL_ORDER-1:0]           next_waddr_o,
  output logic [POOL_ORDER:0]             next_wdata_o,
  output logic [POOL_ORDER-1:0]           prev_waddr_o,
  output logic [POOL_ORDER:0]             prev_wdata_o,
  input  logic [$clog2(POOL_ORDER+1):0]   mark_rdata_i,
  input  logic [POOL_ORDER:0]             next_rdata_i,
  input  logic [POOL_ORDER:0]             prev_rdata_i
);

  localparam int AW     = POOL_ORDER;
  localparam int OW     = $clog2(POOL_ORDER + 1);
  localparam int NLists = POOL_ORDER + 1;
  localparam logic [OW-1:0] MaxOrd = OW'(POOL_ORDER);
  localparam logic [AW:0]   Nil    = {1'b1, {AW{1'b0}}};

  localparam int SW = 5;
  localparam logic [SW-1:0] SClr      = 5'd0;
  localparam logic [SW-1:0] SIdle     = 5'd1;
  localparam logic [SW-1:0] SDec      = 5'd2;
  localparam logic [SW-1:0] SChk      = 5'd3;
  localparam logic [SW-1:0] SFind     = 5'd4;
  localparam logic [SW-1:0] SAlFound  = 5'd5;
  localparam logic [SW-1:0] STkStart  = 5'd6;
  localparam logic [SW-1:0] STkMark   = 5'd7;
  localparam logic [SW-1:0] STkLoop   = 5'd8;
  localparam logic [SW-1:0] STkEnd    = 5'd9;
  localparam logic [SW-1:0] SRelCheck = 5'd10;
  localparam logic [SW-1:0] SRelWait  = 5'd11;
  localparam logic [SW-1:0] SRelNext  = 5'd12;
  localparam logic [SW-1:0] SRelPush  = 5'd13;
  localparam logic [SW-1:0] SShLoop   = 5'd14;
  localparam logic [SW-1:0] SGrCheck  = 5'd15;
  localparam logic [SW-1:0] SGrWait   = 5'd16;
  localparam logic [SW-1:0] SGrDecide = 5'd17;
  localparam logic [SW-1:0] SGrFound  = 5'd18;
  localparam logic [SW-1:0] SGrUnl    = 5'd19;
  localparam logic [SW-1:0] SUlRd     = 5'd20;
  localparam logic [SW-1:0] SUlWr     = 5'd21;
  localparam logic [SW-1:0] SPu1      = 5'd22;
  localparam logic [SW-1:0] SPu2      = 5'd23;
  localparam logic [SW-1:0] SDone     = 5'd24;

  logic [SW-1:0]   state_q, state_d, ret_q, ret_d;
  logic [OpW-1:0]  op_q, op_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic [OrdW-1:0] kraw_q, kraw_d, k2raw_q, k2raw_d;
  logic [AW-1:0]   l_q, l_d, b_q, b_d, res_q, res_d;
  logic [OW-1:0]   j_q, j_d, i_q, i_d, fj_q, fj_d, jabs_q, jabs_d;
  logic            found_q, found_d, mv_q, mv_d;
  logic [StW-1:0]  st_q, st_d;
  logic [AW-1:0]   ul_u_q, ul_u_d, pu_u_q, pu_u_d, pu_x_q, pu_x_d;
  logic [OW-1:0]   ul_k_q, ul_k_d, pu_k_q, pu_k_d;
  logic            pu_tail_q, pu_tail_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [AW:0]     head_q [NLists];
  logic [AW:0]     tail_q [NLists];

  logic            hd_we, tl_we;
  logic [OW-1:0]   hd_idx, tl_idx;
  logic [AW:0]     hd_val, tl_val;

  logic [OW-1:0]   kk, k2k, tk, jm1;
  logic            kbad, k2bad, misal;
  logic [AW:0]     amask;
  logic [AW-1:0]   bw, xl;
  logic            rd_free;
  logic [OW-1:0]   rd_ord;

  assign kk      = OW'(kraw_q);
  assign k2k     = OW'(k2raw_q);
  assign kbad    = 32'(kraw_q) > 32'(POOL_ORDER);
  assign k2bad   = 32'(k2raw_q) > 32'(POOL_ORDER);
  assign amask   = ((AW+1)'(1) << kk) - (AW+1)'(1);
  assign misal   = |(addr_q & amask[AW-1:0]);
  assign tk      = (op_q == OpAlloc) ? kk : k2k;
  assign jm1     = j_q - OW'(1);
  assign rd_free = mark_rdata_i[OW];
  assign rd_ord  = mark_rdata_i[OW-1:0];

  always_comb begin
    state_d = state_q;  ret_d = ret_q;  op_d = op_q;  addr_d = addr_q;
    kraw_d = kraw_q;  k2raw_d = k2raw_q;  l_d = l_q;  b_d = b_q;  res_d = res_q;
    j_d = j_q;  i_d = i_q;  fj_d = fj_q;  jabs_d = jabs_q;  found_d = found_q;
    mv_d = mv_q;  st_d = st_q;  ul_u_d = ul_u_q;  ul_k_d = ul_k_q;
    pu_u_d = pu_u_q;  pu_k_d = pu_k_q;  pu_tail_d = pu_tail_q;  pu_x_d = pu_x_q;
    clr_d = clr_q;
    hd_we = 1'b0;  hd_idx = '0;  hd_val = Nil;
    tl_we = 1'b0;  tl_idx = '0;  tl_val = Nil;
    rd_addr_o = '0;  we_o = '0;
    mark_waddr_o = '0;  mark_wdata_o = '0;
    next_waddr_o = '0;  next_wdata_o = Nil;
    prev_waddr_o = '0;  prev_wdata_o = Nil;
    done_o = 1'b0;
    bw = '0;
    xl = '0;

    unique case (state_q)
      SClr: begin
        we_o.mark    = 1'b1;
        mark_waddr_o = clr_q;
        mark_wdata_o = (clr_q == '0) ? {1'b1, MaxOrd} : '0;
        // unit zero is the lone member of the top list, both links empty
        we_o.nxt     = (clr_q == '0);
        we_o.prv     = (clr_q == '0);
        clr_d        = clr_q + AW'(1);
        if (clr_q == '1) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (start) begin
          op_d    = opcode_i;
          addr_d  = block_address_i;
          kraw_d  = order_i;
          k2raw_d = new_order_i;
          st_d    = StOk;
          res_d   = '0;
          mv_d    = 1'b0;
          state_d = SDec;
        end
      end
      SDec: begin
        unique case (op_q)
          OpAlloc: begin
            if (kbad) begin
              st_d = StBadOrder;  state_d = SDone;
            end else begin
              fj_d = kk;  ret_d = SAlFound;  state_d = SFind;
            end
          end
          OpFree: begin
            if (kbad) begin
              st_d = StBadOrder;  state_d = SDone;
            end else if (misal) begin
              st_d = StBadAddr;  state_d = SDone;
            end else begin
              rd_addr_o = addr_q;  state_d = SChk;
            end
          end
          OpResize: begin
            if (kbad || k2bad) begin
              st_d = StBadOrder;  state_d = SDone;
            end else if (misal) begin
              st_d = StBadAddr;  state_d = SDone;
            end else begin
              rd_addr_o = addr_q;  state_d = SChk;
            end
          end
          default: begin
            st_d = StBadOrder;  state_d = SDone;
          end
        endcase
      end
      SChk: begin
        j_d = kk;
        l_d = addr_q;
        if (rd_free) begin
          st_d = StIsFree;  state_d = SDone;
        end else if (op_q == OpFree) begin
          state_d = SRelCheck;
        end else if (kk >= k2k) begin
          state_d = SShLoop;
        end else begin
          state_d = SGrCheck;
        end
      end
      SFind: begin
        if (!head_q[fj_q][AW]) begin
          found_d = 1'b1;  state_d = ret_q;
        end else if (fj_q == MaxOrd) begin
          found_d = 1'b0;  state_d = ret_q;
        end else begin
          fj_d = fj_q + OW'(1);
        end
      end
      SAlFound: begin
        if (!found_q) begin
          st_d = StNoMem;  state_d = SDone;
        end else begin
          state_d = STkStart;
        end
      end
      STkStart: begin
        l_d     = head_q[fj_q][AW-1:0];
        j_d     = fj_q;
        ul_u_d  = head_q[fj_q][AW-1:0];
        ul_k_d  = fj_q;
        ret_d   = STkMark;
        state_d = SUlRd;
      end
      STkMark: begin
        we_o.mark    = 1'b1;
        mark_waddr_o = l_q;
        mark_wdata_o = {1'b0, tk};
        state_d      = STkLoop;
      end
      STkLoop: begin
        if (j_q > tk) begin
          pu_u_d = l_q + (AW'(1) << jm1);  pu_k_d = jm1;  pu_tail_d = 1'b0;
          j_d = jm1;  ret_d = STkLoop;  state_d = SPu1;
        end else begin
          state_d = STkEnd;
        end
      end
      STkEnd: begin
        res_d = l_q;
        if (op_q == OpAlloc) begin
          state_d = SDone;
        end else begin
          mv_d = 1'b1;  l_d = addr_q;  j_d = jabs_q;  state_d = SRelCheck;
        end
      end
      SRelCheck: begin
        if (j_q < MaxOrd) begin
          bw = l_q ^ (AW'(1) << j_q);
          b_d = bw;  rd_addr_o = bw;  state_d = SRelWait;
        end else begin
          state_d = SRelPush;
        end
      end
      SRelWait: begin
        if (rd_free && rd_ord == j_q) begin
          ul_u_d = b_q;  ul_k_d = j_q;  ret_d = SRelNext;  state_d = SUlRd;
        end else begin
          state_d = SRelPush;
        end
      end
      SRelNext: begin
        if (b_q < l_q) begin
          l_d = b_q;
        end
        j_d = j_q + OW'(1);
        state_d = SRelCheck;
      end
      SRelPush: begin
        pu_u_d = l_q;  pu_k_d = j_q;  pu_tail_d = 1'b0;
        ret_d = SDone;  state_d = SPu1;
      end
      SShLoop: begin
        if (j_q > k2k) begin
          pu_u_d = addr_q + (AW'(1) << jm1);  pu_k_d = jm1;  pu_tail_d = 1'b1;
          j_d = jm1;  ret_d = SShLoop;  state_d = SPu1;
        end else begin
          we_o.mark = 1'b1;  mark_waddr_o = addr_q;  mark_wdata_o = {1'b0, k2k};
          res_d = addr_q;  state_d = SDone;
        end
      end
      SGrCheck: begin
        if (j_q < k2k) begin
          bw = addr_q ^ (AW'(1) << j_q);
          if (bw < addr_q) begin
            state_d = SGrDecide;
          end else begin
            rd_addr_o = bw;  state_d = SGrWait;
          end
        end else begin
          state_d = SGrDecide;
        end
      end
      SGrWait: begin
        if (rd_free && rd_ord == j_q) begin
          j_d = j_q + OW'(1);  state_d = SGrCheck;
        end else begin
          state_d = SGrDecide;
        end
      end
      SGrDecide: begin
        jabs_d = j_q;
        i_d    = kk;
        if (j_q < k2k) begin
          fj_d = k2k;  ret_d = SGrFound;  state_d = SFind;
        end else begin
          state_d = SGrUnl;
        end
      end
      SGrFound: begin
        if (!found_q) begin
          st_d = StNoMem;  state_d = SDone;
        end else begin
          state_d = SGrUnl;
        end
      end
      SGrUnl: begin
        if (i_q < jabs_q) begin
          ul_u_d = addr_q + (AW'(1) << i_q);  ul_k_d = i_q;
          i_d = i_q + OW'(1);  ret_d = SGrUnl;  state_d = SUlRd;
        end else if (jabs_q == k2k) begin
          we_o.mark = 1'b1;  mark_waddr_o = addr_q;  mark_wdata_o = {1'b0, k2k};
          res_d = addr_q;  state_d = SDone;
        end else begin
          state_d = STkStart;
        end
      end
      SUlRd: begin
        rd_addr_o = ul_u_q;
        state_d   = SUlWr;
      end
      SUlWr: begin
        // prev side: next link of predecessor or the list head
        if (!prev_rdata_i[AW]) begin
          we_o.nxt = 1'b1;  next_waddr_o = prev_rdata_i[AW-1:0];
          next_wdata_o = next_rdata_i;
        end else begin
          hd_we = 1'b1;  hd_idx = ul_k_q;  hd_val = next_rdata_i;
        end
        // next side: prev link of successor or the list tail
        if (!next_rdata_i[AW]) begin
          we_o.prv = 1'b1;  prev_waddr_o = next_rdata_i[AW-1:0];
          prev_wdata_o = prev_rdata_i;
        end else begin
          tl_we = 1'b1;  tl_idx = ul_k_q;  tl_val = prev_rdata_i;
        end
        state_d = ret_q;
      end
      SPu1: begin
        we_o.mark = 1'b1;  mark_waddr_o = pu_u_q;  mark_wdata_o = {1'b1, pu_k_q};
        we_o.nxt  = 1'b1;  next_waddr_o = pu_u_q;
        we_o.prv  = 1'b1;  prev_waddr_o = pu_u_q;
        hd_idx = pu_k_q;  tl_idx = pu_k_q;
        if (!pu_tail_q) begin
          next_wdata_o = head_q[pu_k_q];
          prev_wdata_o = Nil;
          hd_we = 1'b1;  hd_val = {1'b0, pu_u_q};
          xl = head_q[pu_k_q][AW-1:0];
          if (!head_q[pu_k_q][AW]) begin
            pu_x_d = xl;  state_d = SPu2;
          end else begin
            tl_we = 1'b1;  tl_val = {1'b0, pu_u_q};  state_d = ret_q;
          end
        end else begin
          prev_wdata_o = tail_q[pu_k_q];
          next_wdata_o = Nil;
          tl_we = 1'b1;  tl_val = {1'b0, pu_u_q};
          xl = tail_q[pu_k_q][AW-1:0];
          if (!tail_q[pu_k_q][AW]) begin
            pu_x_d = xl;  state_d = SPu2;
          end else begin
            hd_we = 1'b1;  hd_val = {1'b0, pu_u_q};  state_d = ret_q;
          end
        end
      end
      SPu2: begin
        if (!pu_tail_q) begin
          we_o.prv = 1'b1;  prev_waddr_o = pu_x_q;  prev_wdata_o = {1'b0, pu_u_q};
        end else begin
          we_o.nxt = 1'b1;  next_waddr_o = pu_x_q;  next_wdata_o = {1'b0, pu_u_q};
        end
        state_d = ret_q;
      end
      SDone: begin
        done_o  = 1'b1;
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr;
      ret_q   <= SIdle;
      clr_q   <= '0;
      found_q <= 1'b0;
      for (int n = 0; n < NLists; n++) begin
        head_q[n] <= (n == POOL_ORDER) ? '0 : Nil;
        tail_q[n] <= (n == POOL_ORDER) ? '0 : Nil;
      end
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      clr_q   <= clr_d;
      found_q <= found_d;
      if (hd_we) begin
        head_q[hd_idx] <= hd_val;
      end
      if (tl_we) begin
        tail_q[tl_idx] <= tl_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_d_reg: begin
      op_q      <= op_d;
      addr_q    <= addr_d;
      kraw_q    <= kraw_d;
      k2raw_q   <= k2raw_d;
      l_q       <= l_d;
      b_q       <= b_d;
      res_q     <= res_d;
      j_q       <= j_d;
      i_q       <= i_d;
      fj_q      <= fj_d;
      jabs_q    <= jabs_d;
      mv_q      <= mv_d;
      st_q      <= st_d;
      ul_u_q    <= ul_u_d;
      ul_k_q    <= ul_k_d;
      pu_u_q    <= pu_u_d;
      pu_k_q    <= pu_k_d;
      pu_tail_q <= pu_tail_d;
      pu_x_q    <= pu_x_d;
    end
  end

  assign busy             = (state_q != SIdle);
  assign result_address_o = res_q;
  assign status_o         = st_q;
  assign moved_o          = mv_q;

endmodule

FILE: src/binary_buddy_allocator_top.sv
// buddy allocator top level: sequencer plus per-unit memories
//
//  channel   | handshake          | fields
//  ----------+--------------------+-----------------------------------------------
//  request   | start high, busy low | opcode_i, block_address_i, order_i, new_order_i
//  result    | done_o for one cycle | result_address_o, status_o, moved_o
//
// one request is worked at a time; busy stays high from the accepting edge through
// the done_o cycle. after reset a clearing pass over every unit writes the mark memory
// and the links of unit zero; busy is high throughout. every step is one access to the
// mark, next and prev memories: an unlink reads links, then rewrites neighbours or ends;
// a push writes the unit and, for a non-empty list, the old head or tail; a mark probe
// sets the address, then reads. allocate scans the lists, then splits per level; free
// merges per level; a shrink cuts per level; a grow probes and absorbs buddies, and a
// move adds an allocate and a free. results cannot be held off by the receiver.
module binary_buddy_allocator_top import bba_pkg::*; #(
  parameter int POOL_ORDER = PoolOrderDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [OpW-1:0]        opcode_i,
  input  logic [POOL_ORDER-1:0] block_address_i,
  input  logic [OrdW-1:0]       order_i,
  input  logic [OrdW-1:0]       new_order_i,
  output logic                  done_o,
  output logic [POOL_ORDER-1:0] result_address_o,
  output logic [StW-1:0]        status_o,
  output logic                  moved_o
);

  localparam int AW = POOL_ORDER;
  localparam int OW = $clog2(POOL_ORDER + 1);

  // memory access lines between sequencer and unit memories
  logic [AW-1:0] rd_addr;
  mem_we_t       mem_we;
  logic [AW-1:0] mark_waddr, next_waddr, prev_waddr;
  logic [OW:0]   mark_wdata, mark_rdata;
  logic [AW:0]   next_wdata, prev_wdata, next_rdata, prev_rdata;

  // sequencer: decode, free-list scan, split, merge, resize
  bba_ctrl #(
    .POOL_ORDER (POOL_ORDER)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .opcode_i         (opcode_i),
    .block_address_i  (block_address_i),
    .order_i          (order_i),
    .new_order_i      (new_order_i),
    .done_o           (done_o),
    .result_address_o (result_address_o),
    .status_o         (status_o),
    .moved_o          (moved_o),
    .rd_addr_o        (rd_addr),
    .we_o             (mem_we),
    .mark_waddr_o     (mark_waddr),
    .mark_wdata_o     (mark_wdata),
    .next_waddr_o     (next_waddr),
    .next_wdata_o     (next_wdata),
    .prev_waddr_o     (prev_waddr),
    .prev_wdata_o     (prev_wdata),
    .mark_rdata_i     (mark_rdata),
    .next_rdata_i     (next_rdata),
    .prev_rdata_i     (prev_rdata)
  );

  // per-unit state, read data registered in the cycle after the address
  bba_mem #(
    .POOL_ORDER (POOL_ORDER)
  ) u_mem (
    .clk_i        (clk_i),
    .rd_addr_i    (rd_addr),
    .we_i         (mem_we),
    .mark_waddr_i (mark_waddr),
    .mark_wdata_i (mark_wdata),
    .next_waddr_i (next_waddr),
    .next_wdata_i (next_wdata),
    .prev_waddr_i (prev_waddr),
    .prev_wdata_i (prev_wdata),
    .mark_rdata_o (mark_rdata),
    .next_rdata_o (next_rdata),
    .prev_rdata_o (prev_rdata)
  );

  // result strobe lasts a single cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done strobe longer than one cycle");

  // a result only appears while a transaction is in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result outside a transaction");

  // errors carry a zero address and no move
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != StOk) |-> (result_address_o == '0 && !moved_o))
    else $error("error result with address or move flag");

  // no memory write may land while idle
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (mem_we == '0)) else $error("memory write while idle");

endmodule

FILE: verif/tb_binary_buddy_allocator_top.sv
// self-checking testbench for the binary buddy allocator top level
module tb_binary_buddy_allocator_top;
  import bba_pkg::*;

  localparam int PoolOrd  = PoolOrderDef;
  localparam int PoolSize = 1 << PoolOrd;
  localparam int NilLink  = PoolSize;
  localparam int NumLists = PoolOrd + 1;
  localparam logic [OpW-1:0] OpNone = 2'd3;   // undefined opcode, no operation
  localparam int NumRandom = 950;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [OpW-1:0]        opcode_i = OpAlloc;
  logic [PoolOrd-1:0]    block_address_i = '0;
  logic [OrdW-1:0]       order_i = '0;
  logic [OrdW-1:0]       new_order_i = '0;
  logic                  done_o;
  logic [PoolOrd-1:0]    result_address_o;
  logic [StW-1:0]        status_o;
  logic                  moved_o;

  binary_buddy_allocator_top #(.POOL_ORDER(PoolOrd)) u_top (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .block_address_i, .order_i,
    .new_order_i, .done_o, .result_address_o, .status_o, .moved_o
  );

  always #2 clk_i = ~clk_i;

  // one expected result transaction
  typedef struct {
    int addr;
    int st;
    int mv;
  } reply_t;

  // one directed stimulus row; typed rows carry their own expected reply
  typedef struct {
    int op;
    int addr;
    int ord;
    int nord;
    bit typed;
    int ea;
    int es;
    int em;
  } row_t;

  // a block the stimulus currently owns
  typedef struct {
    int addr;
    int ord;
  } owned_t;

  reply_t reply_q[$];
  owned_t owned_q[$];
  int     n_errors = 0;
  int     n_accepted = 0;
  int     n_checked = 0;
  int     n_moved = 0;
  int     st_count[8];

  // shadow copy of the allocator state
  bit free_m[PoolSize];
  int hord[PoolSize];
  int nxt[PoolSize];
  int prv[PoolSize];
  int lhead[NumLists];
  int ltail[NumLists];

  function automatic void pool_reset();
    for (int i = 0; i < PoolSize; i++) begin
      free_m[i] = 0;
      hord[i] = 0;
      nxt[i] = 0;
      prv[i] = 0;
    end
    for (int i = 0; i < NumLists; i++) begin
      lhead[i] = NilLink;
      ltail[i] = NilLink;
    end
    free_m[0] = 1;
    hord[0] = PoolOrd;
    nxt[0] = NilLink;
    prv[0] = NilLink;
    lhead[PoolOrd] = 0;
    ltail[PoolOrd] = 0;
  endfunction

  function automatic void list_push_front(int u, int k);
    int h;
    h = lhead[k];
    nxt[u] = h;
    prv[u] = NilLink;
    if (h < PoolSize) prv[h] = u; else ltail[k] = u;
    lhead[k] = u;
  endfunction

  function automatic void list_push_back(int u, int k);
    int t;
    t = ltail[k];
    prv[u] = t;
    nxt[u] = NilLink;
    if (t < PoolSize) nxt[t] = u; else lhead[k] = u;
    ltail[k] = u;
  endfunction

  function automatic void list_unlink(int u, int k);
    int p, n;
    p = prv[u];
    n = nxt[u];
    if (p < PoolSize) nxt[p] = n; else lhead[k] = n;
    if (n < PoolSize) prv[n] = p; else ltail[k] = p;
  endfunction

  function automatic int first_nonempty(int k);
    for (int j = k; j < NumLists; j++)
      if (lhead[j] < PoolSize) return j;
    return NumLists;
  endfunction

  // pop the head of list j and split it down to order k
  function automatic int carve_block(int j, int k);
    int l, h;
    l = lhead[j];
    list_unlink(l, j);
    free_m[l] = 0;
    hord[l] = k;
    while (j > k) begin
      j--;
      h = l + (1 << j);
      free_m[h] = 1;
      hord[h] = j;
      list_push_front(h, j);
    end
    return l;
  endfunction

  // merge with free buddies and push at the list head
  function automatic void coalesce_block(int l, int k);
    int b;
    for (; k < PoolOrd; k++) begin
      b = l ^ (1 << k);
      if (!free_m[b] || hord[b] != k) break;
      list_unlink(b, k);
      if (b < l) l = b;
    end
    free_m[l] = 1;
    hord[l] = k;
    list_push_front(l, k);
  endfunction

  function automatic int block_status(int l, int k);
    if (l >= PoolSize || (PoolSize - l) < (1 << k)) return StBadAddr;
    if ((l & ((1 << k) - 1)) != 0) return StBadAddr;
    if (free_m[l]) return StIsFree;
    return StOk;
  endfunction

  // compute the reply of one request and advance the shadow pool
  function automatic reply_t pool_step(int op, int addr, int k, int k2);
    reply_t r;
    int j, src, h, b;
    r = '{addr: 0, st: StOk, mv: 0};
    if (op == OpAlloc) begin
      if (k > PoolOrd) r.st = StBadOrder;
      else begin
        j = first_nonempty(k);
        if (j >= NumLists) r.st = StNoMem;
        else r.addr = carve_block(j, k);
      end
    end else if (op == OpFree) begin
      if (k > PoolOrd) r.st = StBadOrder;
      else begin
        r.st = block_status(addr, k);
        if (r.st == StOk) coalesce_block(addr, k);
      end
    end else if (op == OpResize) begin
      if (k > PoolOrd || k2 > PoolOrd) r.st = StBadOrder;
      else begin
        r.st = block_status(addr, k);
        if (r.st == StOk && k >= k2) begin
          // shrink in place, cut halves go to list tails
          j = k;
          while (j > k2) begin
            j--;
            h = addr + (1 << j);
            free_m[h] = 1;
            hord[h] = j;
            list_push_back(h, j);
          end
          hord[addr] = k2;
          r.addr = addr;
        end else if (r.st == StOk) begin
          // grow: absorb free upper buddies, else relocate
          j = k;
          src = NumLists;
          while (j < k2) begin
            b = addr ^ (1 << j);
            if (b < addr || !free_m[b] || hord[b] != j) break;
            j++;
          end
          if (j < k2) begin
            src = first_nonempty(k2);
            if (src >= NumLists) r.st = StNoMem;
          end
          if (r.st == StOk) begin
            for (int i = k; i < j; i++) list_unlink(addr + (1 << i), i);
            if (j == k2) begin
              hord[addr] = k2;
              r.addr = addr;
            end else begin
              r.addr = carve_block(src, k2);
              coalesce_block(addr, j);
              r.mv = 1;
            end
          end
        end
      end
    end else begin
      r.st = StBadOrder;
    end
    return r;
  endfunction

  function automatic int owned_index(int addr, int ord);
    for (int i = 0; i < owned_q.size(); i++)
      if (owned_q[i].addr == addr && owned_q[i].ord == ord) return i;
    return -1;
  endfunction

  // drive one request and wait for the accepting edge, then predict it
  task automatic issue(int op, int addr, int k, int k2, bit typed, reply_t typed_r);
    reply_t r;
    int idx;
    start <= 1'b1;
    opcode_i <= op[OpW-1:0];
    block_address_i <= addr[PoolOrd-1:0];
    order_i <= k[OrdW-1:0];
    new_order_i <= k2[OrdW-1:0];
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    idx = owned_index(addr, k);
    r = pool_step(op, addr, k, k2);
    n_accepted++;
    // keep the list of owned blocks in step with the pool
    if (r.st == StOk) begin
      if (op == OpAlloc) owned_q.push_back('{addr: r.addr, ord: k});
      else if (op == OpFree && idx >= 0) owned_q.delete(idx);
      else if (op == OpResize && idx >= 0) owned_q[idx] = '{addr: r.addr, ord: k2};
    end
    reply_q.push_back(typed ? typed_r : r);
  endtask

  task automatic idle_gap();
    int p, g;
    p = $urandom_range(0, 99);
    if (p < 50) g = 0;
    else if (p < 85) g = $urandom_range(1, 3);
    else if (p < 97) g = $urandom_range(4, 12);
    else g = $urandom_range(20, 60);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic int pick_order();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(0, 3);
    if (p < 90) return $urandom_range(4, 7);
    if (p < 97) return $urandom_range(8, PoolOrd);
    return $urandom_range(PoolOrd + 1, 15);
  endfunction

  // directed rows: reset state, extremes, every error code, grow and shrink paths
  row_t dir_rows[24] = '{
    '{OpAlloc,    0,   10, 0,  1, 0, StOk,       0},
    '{OpAlloc,    0,    0, 0,  1, 0, StNoMem,    0},
    '{OpFree,     0,   10, 0,  1, 0, StOk,       0},
    '{OpFree,     0,   10, 0,  1, 0, StIsFree,   0},
    '{OpAlloc,    0,   11, 0,  1, 0, StBadOrder, 0},
    '{OpNone,     1023, 15, 15, 1, 0, StBadOrder, 0},
    '{OpFree,     1,    1, 0,  1, 0, StBadAddr,  0},
    '{OpFree,     1023, 15, 0, 1, 0, StBadOrder, 0},
    '{OpResize,   0,   10, 15, 1, 0, StBadOrder, 0},
    '{OpAlloc,    0,    0, 0,  0, 0, 0, 0},
    '{OpAlloc,    0,    0, 0,  0, 0, 0, 0},
    '{OpResize,   0,    0, 1,  0, 0, 0, 0},
    '{OpResize,   2,    1, 0,  0, 0, 0, 0},
    '{OpFree,     1023, 1, 0,  1, 0, StBadAddr,  0},
    '{OpResize,   2,    0, 10, 0, 0, 0, 0},
    '{OpFree,     1,    0, 0,  0, 0, 0, 0},
    '{OpResize,   2,    0, 1,  0, 0, 0, 0},
    '{OpResize,   2,    1, 3,  0, 0, 0, 0},
    '{OpAlloc,    0,   10, 0,  1, 0, StNoMem,    0},
    '{OpResize,   8,    3, 3,  0, 0, 0, 0},
    '{OpFree,     8,    3, 0,  0, 0, 0, 0},
    '{OpAlloc,    0,    9, 0,  0, 0, 0, 0},
    '{OpResize,   0,    9, 10, 0, 0, 0, 0},
    '{OpFree,     0,   10, 0,  1, 0, StOk,       0}
  };

  // result checker: every done_o pulse must match the oldest expectation
  always @(posedge clk_i) begin
    reply_t e;
    if (rst_ni && done_o) begin
      if (reply_q.size() == 0) begin
        $error("result with nothing expected: addr %0d status %0d moved %0d",
               result_address_o, status_o, moved_o);
        n_errors++;
      end else begin
        e = reply_q.pop_front();
        n_checked++;
        st_count[status_o]++;
        if (moved_o) n_moved++;
        if (result_address_o !== e.addr[PoolOrd-1:0]) begin
          $error("result_address: expected %0d, got %0d", e.addr, result_address_o);
          n_errors++;
        end
        if (status_o !== e.st[StW-1:0]) begin
          $error("status: expected %0d, got %0d", e.st, status_o);
          n_errors++;
        end
        if (moved_o !== e.mv[0]) begin
          $error("moved: expected %0d, got %0d", e.mv, moved_o);
          n_errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    reply_t tr;
    int p, op, a, k, k2, idx, drain;
    for (int i = 0; i < 8; i++) st_count[i] = 0;
    pool_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      tr = '{addr: dir_rows[i].ea, st: dir_rows[i].es, mv: dir_rows[i].em};
      issue(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].ord, dir_rows[i].nord,
            dir_rows[i].typed, tr);
      idle_gap();
    end

    // random traffic: mostly well-formed requests on owned blocks, some noise
    for (int n = 0; n < NumRandom; n++) begin
      // hold off once until every outstanding result is back
      if (n == NumRandom / 2) begin
        start <= 1'b0;
        while (reply_q.size() != 0) @(posedge clk_i);
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      p = $urandom_range(0, 99);
      a = 0;
      k = 0;
      k2 = $urandom_range(0, 15);
      if (p < 40 || (p < 85 && owned_q.size() == 0)) begin
        op = OpAlloc;
        k = pick_order();
        a = $urandom_range(0, PoolSize - 1);
      end else if (p < 65) begin
        idx = $urandom_range(0, owned_q.size() - 1);
        op = OpFree;
        a = owned_q[idx].addr;
        k = owned_q[idx].ord;
      end else if (p < 85) begin
        idx = $urandom_range(0, owned_q.size() - 1);
        op = OpResize;
        a = owned_q[idx].addr;
        k = owned_q[idx].ord;
        if ($urandom_range(0, 9) != 0) k2 = $urandom_range(0, (k + 3 > 10) ? 10 : k + 3);
      end else begin
        // noise: random fields, kept away from requests that would corrupt the pool
        op = $urandom_range(0, 3);
        a = $urandom_range(0, PoolSize - 1);
        k = $urandom_range(0, 15);
        if ((op == OpFree || op == OpResize) && k <= PoolOrd &&
            !(op == OpResize && k2 > PoolOrd) &&
            block_status(a, k) == StOk && owned_index(a, k) < 0)
          k = $urandom_range(PoolOrd + 1, 15);
      end
      issue(op, a, k, k2, 1'b0, tr);
      idle_gap();
    end
    start <= 1'b0;

    while (reply_q.size() != 0) @(posedge clk_i);
    drain = 200;
    repeat (drain) @(posedge clk_i);

    $display("covered %0d requests, %0d results: ok %0d, no memory %0d, bad order %0d,",
             n_accepted, n_checked, st_count[StOk], st_count[StNoMem], st_count[StBadOrder]);
    $display("  bad address %0d, already free %0d, relocating resizes %0d",
             st_count[StBadAddr], st_count[StIsFree], n_moved);
    if (n_errors == 0 && reply_q.size() == 0) begin
      $display("tb_binary_buddy_allocator_top: done, clean");
    end else begin
      $display("tb_binary_buddy_allocator_top: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10000000;
    $display("tb_binary_buddy_allocator_top: done, errors");
    $finish;
  end

endmodule
